/* hdl/fpsa_pkg.sv */
package fpsa_pkg;

  // Field widths
  localparam int FRAME_W  = 20;
  localparam int STATUS_W = 3;

  // Default sizing
  localparam int DEF_STACK_DEPTH      = 4096;
  localparam int DEF_ENTRIES_PER_PAGE = 1024;

  // Highest frame number the bump pointer may reach
  localparam logic [FRAME_W-1:0] FRAME_MAX = 20'hFFFFF;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Paging modes
  localparam logic MODE_BUMP  = 1'b0;
  localparam logic MODE_STACK = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSORBED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd5;

  typedef struct packed {
    logic               operation;
    logic [FRAME_W-1:0] frame_in;
  } in_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_out;
    logic [STATUS_W-1:0] status;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;      // request transfer taken this cycle
    logic load_pop;  // capture popped frame into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_pop;    // current request is a stack-mode allocate that finds an entry
  } sts_t;

endpackage

/* hdl/free_page_stack_allocator_unit.sv */
// Page frame allocator on 20-bit frame numbers. With cfg_wdata written 0 an
// allocate hands out the next bump frame (the first is 1); with 1 it pops the
// free stack, and an empty stack answers out of memory. A free of a frame
// below the bump pointer is ignored; a free that finds the stack full is
// taken as storage and grows capacity by ENTRIES_PER_PAGE up to STACK_DEPTH,
// after which further such frees are dropped. Every request yields exactly one
// result. Frees, bump allocates and out-of-memory answers are registered, so the
// result is valid in the cycle after the request transfer; a stack pop's result
// waits on the registered read of the stack RAM and then the S_POP state. A new
// request is taken in the cycle the previous result is transferred. The stack
// RAM needs no clearing after reset: entries are read only after they are written.
module free_page_stack_allocator_unit #(
  parameter int STACK_DEPTH      = fpsa_pkg::DEF_STACK_DEPTH,
  parameter int ENTRIES_PER_PAGE = fpsa_pkg::DEF_ENTRIES_PER_PAGE
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpsa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output fpsa_pkg::out_t out_data
);
  import fpsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fpsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpsa_dp #(
    .STACK_DEPTH      (STACK_DEPTH),
    .ENTRIES_PER_PAGE (ENTRIES_PER_PAGE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

/* hdl/fpsa_ram.sv */
module fpsa_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/fpsa_ctrl.sv */
module fpsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  fpsa_pkg::sts_t sts,
  output fpsa_pkg::cmd_t cmd
);
  import fpsa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic exec;

  // Take a request only in idle and when the output slot is free or being emptied
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign exec     = in_valid && in_ready;

  assign cmd.exec     = exec;
  assign cmd.load_pop = (state_r == S_POP);

  // Sequence: most requests go straight to a valid result; a stack pop passes through S_POP first
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (exec) begin
          if (sts.is_pop) begin
            state_nxt = S_POP;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_POP: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/fpsa_dp.sv */
module fpsa_dp #(
  parameter int STACK_DEPTH      = 4096,
  parameter int ENTRIES_PER_PAGE = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  fpsa_pkg::in_t  in_data,
  input  fpsa_pkg::cmd_t cmd,
  output fpsa_pkg::sts_t sts,
  output fpsa_pkg::out_t out_data
);
  import fpsa_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = $clog2(ENTRIES_PER_PAGE + 1);
  localparam int XW = ((CW > EW) ? CW : EW) + 1;

  logic               mode_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      cap_r, cap_nxt;
  logic [FRAME_W-1:0] bump_r, bump_nxt;
  out_t               out_r, out_nxt;

  logic [CW-1:0]      count_dec;
  logic [FRAME_W-1:0] bump_inc;
  logic [XW-1:0]      room;
  logic               ram_we, ram_re;
  logic [FRAME_W-1:0] ram_rdata;

  // Only a stack-mode allocate that finds an entry reads the RAM
  assign sts.is_pop = (in_data.operation == OP_ALLOC) && (mode_r == MODE_STACK) &&
                      (count_r != '0);

  assign count_dec = count_r - CW'(1);
  assign bump_inc  = bump_r + FRAME_W'(1);
  assign room      = XW'(STACK_DEPTH) - XW'(cap_r);

  // Decide the result and next state for one request
  always_comb begin
    count_nxt = count_r;
    cap_nxt   = cap_r;
    bump_nxt  = bump_r;
    out_nxt   = out_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    if (cmd.load_pop) begin
      out_nxt.frame_out = ram_rdata;
      out_nxt.status    = ST_ALLOCATED;
    end else if (cmd.exec) begin
      out_nxt.frame_out = '0;
      if (in_data.operation == OP_ALLOC) begin
        if (mode_r == MODE_STACK) begin
          // Pop: read top entry; the S_POP state captures it into the output register
          if (count_r == '0) begin
            out_nxt.status = ST_OOM;
          end else begin
            ram_re    = 1'b1;
            count_nxt = count_dec;
          end
        end else if (bump_r >= FRAME_MAX) begin
          out_nxt.status = ST_OOM;
        end else begin
          bump_nxt          = bump_inc;
          out_nxt.frame_out = bump_inc;
          out_nxt.status    = ST_ALLOCATED;
        end
      end else if (in_data.frame_in < bump_r) begin
        out_nxt.status = ST_IGNORED;
      end else if (count_r >= cap_r) begin
        // Stack full: grow capacity with the freed page, saturating at STACK_DEPTH, else drop it
        if (cap_r >= CW'(STACK_DEPTH)) begin
          out_nxt.status = ST_DROPPED;
        end else begin
          if (XW'(ENTRIES_PER_PAGE) >= room) begin
            cap_nxt = CW'(STACK_DEPTH);
          end else begin
            cap_nxt = CW'(XW'(cap_r) + XW'(ENTRIES_PER_PAGE));
          end
          out_nxt.status = ST_ABSORBED;
        end
      end else begin
        ram_we         = 1'b1;
        count_nxt      = count_r + CW'(1);
        out_nxt.status = ST_PUSHED;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BUMP;
      count_r <= '0;
      cap_r   <= '0;
      bump_r  <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      bump_r  <= bump_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data = out_r;

  fpsa_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_data.frame_in),
    .re    (ram_re),
    .raddr (count_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

endmodule

/* hdl/fpsa_chk.sv */
module fpsa_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input fpsa_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input fpsa_pkg::out_t out_data
);
  import fpsa_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_DROPPED)
    else $error("undefined status code");

  // Only an allocation carries a frame
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_ALLOCATED |-> out_data.frame_out == '0)
    else $error("non-zero frame on a non-allocation result");

  // Never take a request while a stalled result would be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken with output slot full");

endmodule

bind free_page_stack_allocator_unit fpsa_chk u_fpsa_chk (.*);

/* verif/free_page_stack_allocator_unit_tb.sv */
module free_page_stack_allocator_unit_tb;
  import fpsa_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Allocator state as the testbench predicts it
  logic               mode_model = MODE_BUMP;
  logic [FRAME_W-1:0] bump_ptr = '0;
  int unsigned        stack_held = 0;
  int unsigned        stack_room = 0;
  logic [FRAME_W-1:0] frame_stack [DEF_STACK_DEPTH];

  out_t pending_results[$];
  int   mismatch_count = 0;
  bit   idle_en = 1'b1;
  int   hold_off_cycles = 0;

  free_page_stack_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Work out the result of one request and advance the predicted state
  function automatic out_t predict_allocation(in_t req);
    out_t        res;
    int unsigned room;
    res.frame_out = '0;
    res.status    = ST_ALLOCATED;
    if (req.operation == OP_ALLOC) begin
      if (mode_model == MODE_STACK) begin
        if (stack_held == 0) begin
          res.status = ST_OOM;
        end else begin
          stack_held--;
          res.frame_out = frame_stack[stack_held];
        end
      end else if (bump_ptr >= FRAME_MAX) begin
        res.status = ST_OOM;
      end else begin
        bump_ptr++;
        res.frame_out = bump_ptr;
      end
    end else if (req.frame_in < bump_ptr) begin
      res.status = ST_IGNORED;
    end else if (stack_held >= stack_room) begin
      if (stack_room >= DEF_STACK_DEPTH) begin
        res.status = ST_DROPPED;
      end else begin
        // freed page becomes storage for more stack entries
        room = DEF_STACK_DEPTH - stack_room;
        stack_room = (DEF_ENTRIES_PER_PAGE >= room) ? DEF_STACK_DEPTH
                                                   : stack_room + DEF_ENTRIES_PER_PAGE;
        res.status = ST_ABSORBED;
      end
    end else begin
      frame_stack[stack_held] = req.frame_in;
      stack_held++;
      res.status = ST_PUSHED;
    end
    return res;
  endfunction

  // Offer one request after a random gap and predict it once transferred
  task automatic send_request(input logic op, input logic [FRAME_W-1:0] frame);
    in_t req;
    int  gap;
    req.operation = op;
    req.frame_in  = frame;
    gap = idle_en ? $urandom_range(17, 0) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_allocation(req));
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe settle
  task automatic drain_block();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_paging_mode(input logic mode);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    mode_model = mode;
  endtask

  // Free frame at or above the bump pointer, so it reaches the stack logic
  function automatic logic [FRAME_W-1:0] frame_above_bump();
    return FRAME_W'($urandom_range(int'(FRAME_MAX), int'(bump_ptr)));
  endfunction

  // Receiver: draw a stall per result, or take a requested long hold-off
  initial begin : result_receiver
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = idle_en ? $urandom_range(17, 0) : 0;
      end
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, got frame %h status %0d",
                 $time, out_data.frame_out, out_data.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.frame_out !== want.frame_out) begin
          $display("%0t: frame_out mismatch, expected %h, got %h",
                   $time, want.frame_out, out_data.frame_out);
          mismatch_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_data.status);
          mismatch_count++;
        end
      end
    end
  end

  // Absorb, push, ignore, bump order, LIFO pops and the empty stack
  task automatic test_directed();
    send_request(OP_FREE, '0);
    send_request(OP_FREE, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, FRAME_MAX);
    send_request(OP_FREE, 20'd1);
    send_request(OP_FREE, FRAME_MAX);
    send_request(OP_FREE, 20'd2);
    set_paging_mode(MODE_STACK);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, FRAME_MAX);
    send_request(OP_FREE, 20'h55555);
    send_request(OP_FREE, 20'hAAAAA);
    send_request(OP_ALLOC, '0);
    set_paging_mode(MODE_BUMP);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 20'd3);
  endtask

  // Hold the result side off for a long stretch while requests keep coming
  task automatic test_input_stall_under_hold();
    drain_block();
    idle_en = 1'b0;
    hold_off_cycles = 400;
    repeat (12) send_request(1'($urandom_range(1, 0)), frame_above_bump());
    drain_block();
    idle_en = 1'b1;
  endtask

  task automatic test_random_traffic(input int count);
    logic               op;
    logic [FRAME_W-1:0] frame;
    int                 pick;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      if (mode_model == MODE_STACK) op = (pick < 50) ? OP_ALLOC : OP_FREE;
      else op = (pick < 60) ? OP_ALLOC : OP_FREE;
      pick = $urandom_range(99, 0);
      if (pick < 80) frame = frame_above_bump();
      else if (pick < 90 && bump_ptr != '0)
        frame = FRAME_W'($urandom_range(int'(bump_ptr) - 1, 0));
      else frame = FRAME_W'($urandom);
      send_request(op, frame);
    end
  endtask

  // Free the top frame, free below the bump, then pop the stack dry and beyond
  task automatic test_stack_drain();
    set_paging_mode(MODE_STACK);
    idle_en = 1'b0;
    send_request(OP_FREE, FRAME_MAX);
    if (bump_ptr != '0) send_request(OP_FREE, bump_ptr - 1'b1);
    while (stack_held > 0) send_request(OP_ALLOC, '0);
    repeat (2) send_request(OP_ALLOC, '0);
    idle_en = 1'b1;
    drain_block();
  endtask

  initial begin : main_sequence
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed();
    test_input_stall_under_hold();
    for (int phase = 0; phase < 6; phase++) begin
      set_paging_mode((phase % 3 == 0) ? MODE_BUMP : MODE_STACK);
      idle_en = (phase % 2 == 0);
      test_random_traffic(150);
    end
    idle_en = 1'b1;
    test_stack_drain();

    drain_block();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* free_page_stack_allocator_unit.f */
hdl/fpsa_pkg.sv
hdl/fpsa_ram.sv
hdl/fpsa_ctrl.sv
hdl/fpsa_dp.sv
hdl/free_page_stack_allocator_unit.sv
hdl/fpsa_chk.sv
verif/free_page_stack_allocator_unit_tb.sv
